// ===== hw/rtl/digit_display_formatter_macros.svh =====
// Assertion macros shared by the checker files of the digit display formatter.
// The macros expect signals named clk and rst_n in the scope where they are used.
`ifndef DIGIT_DISPLAY_FORMATTER_MACROS_SVH
`define DIGIT_DISPLAY_FORMATTER_MACROS_SVH

// Checked on every rising edge, switched off while reset is asserted.
`define DDF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define DDF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ddf_pkg.sv =====
`timescale 1ns / 1ps
// Package for the digit display formatter: sizes, request codes and glyph constants.
// No dependencies; imported by the top level and by its checker.
package ddf_pkg;

  localparam int ROWS        = 3;
  localparam int DIGITS      = 6;
  localparam int VALUE_W     = 31;
  localparam int ROW_W       = 2;
  localparam int CELL_W      = 3;
  localparam int GLYPH_W     = 5;
  localparam int REQ_W       = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;
  localparam int BCD_W       = DIGITS * 4;
  localparam int IDX_W       = $clog2(ROWS * DIGITS);
  localparam int BIT_CNT_W   = $clog2(VALUE_W);

  localparam logic [REQ_W-1:0] REQ_HEX   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DEC   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  localparam logic [GLYPH_W-1:0] BLANK_GLYPH = 5'd16;

endpackage

// ===== hw/rtl/digit_display_formatter.sv =====
`timescale 1ns / 1ps
// Digit display formatter: turns a value into a row of hex or decimal glyphs
// with leading blanking and reports, per cell, whether the glyph changed.
// Depends on ddf_pkg.
//
// Usage:
//   Input words arrive on in_* (tuser = request kind, tdata = row and value).
//   A set request (hex or decimal) for a valid row produces DIGITS output words
//   on out_*, one per cell from left to right; tlast marks the rightmost cell.
//   A clear request blanks every stored cell and produces no output words.
//   Unused request codes and rows beyond the display are dropped silently.
// Timing:
//   The value is shifted in one bit per cycle through a BCD double-dabble
//   register (hex mode skips the add-3 correction). The cells then leave
//   one per cycle through the output register as long as the receiver
//   accepts them. in_tready is high only while no conversion or emission
//   is running.
// Reset and stall:
//   rst_n (synchronous) returns the control to idle and blanks every cell.
//   A stalled receiver holds the current word; emission simply waits.
module digit_display_formatter
  import ddf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [1:0] row_select, [32:2] value, rest zero
  input  logic [REQ_W-1:0]       in_tuser,   // [1:0] req_type
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [1:0] out_row, [4:2] cell_index, [9:5] glyph
  output logic                   out_tuser,  // [0] changed
  output logic                   out_tlast
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [VALUE_W-1:0]   bin_r, bin_nxt;
  logic [BCD_W-1:0]     bcd_r, bcd_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 dec_r, dec_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [CELL_W-1:0]    cell_r, cell_nxt;
  logic                 seen_r, seen_nxt;

  logic [GLYPH_W-1:0]   shown_r [ROWS*DIGITS];

  logic                 out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]     out_row_r;
  logic [CELL_W-1:0]    out_cell_r;
  logic [GLYPH_W-1:0]   out_glyph_r;
  logic                 out_changed_r;
  logic                 out_last_r;

  logic                 in_acc;
  logic [REQ_W-1:0]     in_req;
  logic [ROW_W-1:0]     in_row;
  logic                 start_set;
  logic                 start_clear;
  logic [BCD_W-1:0]     bcd_adj;
  logic [3:0]           top_digit;
  logic                 last_cell;
  logic                 seen_now;
  logic [GLYPH_W-1:0]   cell_glyph;
  logic [IDX_W-1:0]     cell_idx;
  logic                 out_load;

  assign in_tready   = (state_r == ST_IDLE);
  assign in_acc      = in_tvalid && in_tready;
  assign in_req      = in_tuser;
  assign in_row      = in_tdata[ROW_W-1:0];
  assign start_set   = in_acc && ((in_req == REQ_HEX) || (in_req == REQ_DEC))
                       && ({1'b0, in_row} < (ROW_W+1)'(ROWS));
  assign start_clear = in_acc && (in_req == REQ_CLEAR);

  // Double-dabble correction: in decimal mode each digit of five or more gets
  // three added before the shift. Digits are independent, so this is one narrow level.
  always_comb begin
    bcd_adj = bcd_r;
    for (int d = 0; d < DIGITS; d++) begin
      if (dec_r && (bcd_r[d*4 +: 4] >= 4'd5)) begin
        bcd_adj[d*4 +: 4] = bcd_r[d*4 +: 4] + 4'd3;
      end
    end
  end

  // Leading cells stay blank until the first nonzero digit, but the rightmost
  // cell always shows. When digits were dropped off the top, nothing is blanked.
  assign top_digit  = bcd_r[BCD_W-1 -: 4];
  assign last_cell  = (cell_r == CELL_W'(DIGITS - 1));
  assign seen_now   = seen_r || (top_digit != 4'd0) || ovf_r || last_cell;
  assign cell_glyph = seen_now ? {1'b0, top_digit} : BLANK_GLYPH;
  assign cell_idx   = IDX_W'(row_r) * IDX_W'(DIGITS) + IDX_W'(cell_r);
  assign out_load   = (state_r == ST_EMIT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt   = state_r;
    bin_nxt     = bin_r;
    bcd_nxt     = bcd_r;
    ovf_nxt     = ovf_r;
    dec_nxt     = dec_r;
    row_nxt     = row_r;
    bit_cnt_nxt = bit_cnt_r;
    cell_nxt    = cell_r;
    seen_nxt    = seen_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start_set) begin
          bin_nxt     = in_tdata[ROW_W +: VALUE_W];
          bcd_nxt     = '0;
          ovf_nxt     = 1'b0;
          dec_nxt     = (in_req == REQ_DEC);
          row_nxt     = in_row;
          bit_cnt_nxt = '0;
          state_nxt   = ST_CONV;
        end
      end
      ST_CONV: begin
        bin_nxt     = {bin_r[VALUE_W-2:0], 1'b0};
        bcd_nxt     = {bcd_adj[BCD_W-2:0], bin_r[VALUE_W-1]};
        ovf_nxt     = ovf_r || bcd_adj[BCD_W-1];
        bit_cnt_nxt = bit_cnt_r + BIT_CNT_W'(1);
        if (bit_cnt_r == BIT_CNT_W'(VALUE_W - 1)) begin
          cell_nxt  = '0;
          seen_nxt  = 1'b0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          bcd_nxt  = {bcd_r[BCD_W-5:0], 4'd0};
          cell_nxt = cell_r + CELL_W'(1);
          seen_nxt = seen_now;
          if (last_cell) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r     <= bin_nxt;
    bcd_r     <= bcd_nxt;
    ovf_r     <= ovf_nxt;
    dec_r     <= dec_nxt;
    row_r     <= row_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    cell_r    <= cell_nxt;
    seen_r    <= seen_nxt;
    if (out_load) begin
      out_row_r     <= row_r;
      out_cell_r    <= cell_r;
      out_glyph_r   <= cell_glyph;
      out_changed_r <= (shown_r[cell_idx] != cell_glyph);
      out_last_r    <= last_cell;
    end
  end

  // Glyph store: blanked by reset and by a clear request, one cell written
  // per emitted word.
  always_ff @(posedge clk) begin
    if (!rst_n || start_clear) begin
      for (int i = 0; i < ROWS * DIGITS; i++) begin
        shown_r[i] <= BLANK_GLYPH;
      end
    end else if (out_load) begin
      shown_r[cell_idx] <= cell_glyph;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - ROW_W - CELL_W - GLYPH_W)'(0),
                       out_glyph_r, out_cell_r, out_row_r};
  assign out_tuser  = out_changed_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== hw/rtl/ddf_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the digit display formatter, bound to the top level.
// Depends on ddf_pkg and digit_display_formatter_macros.svh.
`include "digit_display_formatter_macros.svh"

module ddf_checker
  import ddf_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic [REQ_W-1:0]       in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser,
  input logic                   out_tlast
);

  logic set_acc;

  assign set_acc = in_tvalid && in_tready
                   && ((in_tuser == REQ_HEX) || (in_tuser == REQ_DEC))
                   && ({1'b0, in_tdata[ROW_W-1:0]} < (ROW_W+1)'(ROWS));

  // A stalled output word stays put.
  `DDF_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "output word changed while stalled")

  // The rightmost cell, and only that one, closes the run.
  `DDF_ASSERT(a_last_cell, out_tvalid |-> (out_tlast == (out_tdata[4:2] == CELL_W'(DIGITS - 1))), "tlast does not match the rightmost cell")

  // Glyphs are a digit or the blank code.
  `DDF_ASSERT(a_glyph_range, out_tvalid |-> (out_tdata[9:5] <= BLANK_GLYPH), "glyph code out of range")

  // A set request occupies the block, so no further word is taken next cycle.
  `DDF_ASSERT(a_busy_after_set, set_acc |=> !in_tready, "input ready right after a set request")

  // Reset leaves no stale word on the output.
  `DDF_ASSERT_RST(a_reset_clears, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

bind digit_display_formatter ddf_checker u_ddf_checker (.*);
